// File: hw/rtl/rwrd_pkg.sv
// ----------------------------------------------------------------------------
// rwrd_pkg
// Shared types and constants for the retransmit window reroute detector.
// ----------------------------------------------------------------------------
`default_nettype none

package rwrd_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int WINDOW_BINS = 10;
	localparam int IP_W        = 32;
	localparam int CNT_W       = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] THR_RESET  = CNT_W'(2);

	// packet as classified by the front end
	typedef struct packed {
		logic [IDX_W-1:0] slot;
		logic [IP_W-1:0]  ip;
		logic             rtx;
		logic             tick;
		logic             evict;
		logic             counted;
	} item_t;

	// one flow table entry
	typedef struct packed {
		logic            mark;
		logic [IP_W-1:0] ip;
	} entry_t;

	// queue status seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

endpackage

`default_nettype wire

// File: hw/rtl/rwrd_front.sv
// ----------------------------------------------------------------------------
// rwrd_front
// Accepts packets, classifies them as counted or not, and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module rwrd_front (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire  [rwrd_pkg::IDX_W-1:0]  table_index,
	input  wire  [rwrd_pkg::IP_W-1:0]   flow_ip,
	input  wire                         retransmit,
	input  wire                         window_tick,
	input  wire                         flow_timed_out,
	input  wire  [rwrd_pkg::CNT_W-1:0]  payload_length,
	input  wire                         not_syn,
	output rwrd_pkg::qhead_t            head,
	input  wire                         pop
);

	rwrd_pkg::item_t                  q_mem_q [rwrd_pkg::QUEUE_DEPTH];
	logic [rwrd_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [rwrd_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [rwrd_pkg::QPTR_W:0]        count_q;
	rwrd_pkg::item_t                  new_item;
	logic                             push;

	always_comb begin
		new_item.slot    = table_index;
		new_item.ip      = flow_ip;
		new_item.rtx     = retransmit;
		new_item.tick    = window_tick;
		new_item.evict   = flow_timed_out;
		new_item.counted = (payload_length != '0) && not_syn;
	end

	assign in_stall   = (count_q == (rwrd_pkg::QPTR_W+1)'(rwrd_pkg::QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign head.valid = (count_q != '0);
	assign head.item  = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/rwrd_back.sv
// ----------------------------------------------------------------------------
// rwrd_back
// Flow table read-modify-write, sliding window bins and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rwrd_back (
	input  wire                         clk,
	input  wire                         arst_n,
	input  rwrd_pkg::qhead_t            head,
	output logic                        pop,
	input  wire  [rwrd_pkg::CNT_W-1:0]  threshold,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic                        next_hop,
	output logic                        reroute_triggered,
	output logic [rwrd_pkg::CNT_W-1:0]  window_total
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t                          state_q;
	rwrd_pkg::entry_t                table_mem [rwrd_pkg::TABLE_DEPTH];
	logic [rwrd_pkg::TABLE_DEPTH-1:0] vld_q;
	rwrd_pkg::entry_t                rd_s1;
	logic                            rd_vld_s1;
	rwrd_pkg::item_t                 item_s1;

	logic [rwrd_pkg::CNT_W-1:0]      bins_q [rwrd_pkg::WINDOW_BINS];
	logic [rwrd_pkg::CNT_W-1:0]      bins_n [rwrd_pkg::WINDOW_BINS];
	logic [rwrd_pkg::CNT_W-1:0]      sum_q;
	logic [rwrd_pkg::CNT_W-1:0]      sum_adv;
	logic [rwrd_pkg::CNT_W-1:0]      sum_n;
	logic                            hop_q;

	logic                            out_free;
	logic                            exec;
	logic [rwrd_pkg::IP_W-1:0]       res_ip;
	logic                            res_mark;
	logic                            empty;
	logic                            hit;
	logic                            add;
	logic                            we;
	logic                            mark_new;
	logic                            trig;

	assign out_free = !out_valid || !out_stall;
	assign pop      = (state_q == ST_IDLE) && head.valid;
	assign exec     = (state_q == ST_EXEC) && out_free;

	// table entry decode
	always_comb begin
		res_ip   = rd_vld_s1 ? rd_s1.ip : '0;
		res_mark = rd_vld_s1 ? rd_s1.mark : 1'b0;
		empty    = (res_ip == '0);
		hit      = (res_ip == item_s1.ip);
		add      = 1'b0;
		we       = 1'b0;
		mark_new = 1'b0;
		if (item_s1.counted) begin
			if (empty) begin
				we       = 1'b1;
				add      = item_s1.rtx;
				mark_new = item_s1.rtx;
			end else if (hit) begin
				add      = item_s1.rtx && !res_mark;
				we       = add;
				mark_new = 1'b1;
			end else if (item_s1.evict) begin
				we       = 1'b1;
				add      = item_s1.rtx && !res_mark;
				mark_new = add;
			end
		end
	end

	// window: retire oldest on a counted tick, then count into newest
	always_comb begin
		for (int i = 0; i < rwrd_pkg::WINDOW_BINS; i++) begin
			bins_n[i] = bins_q[i];
		end
		sum_adv = sum_q;
		if (item_s1.counted && item_s1.tick) begin
			sum_adv = (sum_q >= bins_q[0]) ? (sum_q - bins_q[0]) : '0;
			for (int i = 0; i < rwrd_pkg::WINDOW_BINS - 1; i++) begin
				bins_n[i] = bins_q[i+1];
			end
			bins_n[rwrd_pkg::WINDOW_BINS-1] = '0;
		end
		sum_n = sum_adv;
		if (add) begin
			if (bins_n[rwrd_pkg::WINDOW_BINS-1] != rwrd_pkg::CNT_MAX) begin
				bins_n[rwrd_pkg::WINDOW_BINS-1] = bins_n[rwrd_pkg::WINDOW_BINS-1] +
					rwrd_pkg::CNT_W'(1);
			end
			if (sum_adv != rwrd_pkg::CNT_MAX) begin
				sum_n = sum_adv + rwrd_pkg::CNT_W'(1);
			end
		end
		trig = item_s1.counted && (sum_n >= threshold);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_s1     <= table_mem[head.item.slot];
			rd_vld_s1 <= vld_q[head.item.slot];
			item_s1   <= head.item;
		end
		if (exec && we) begin
			table_mem[item_s1.slot] <= '{mark: mark_new, ip: item_s1.ip};
		end
		if (exec) begin
			next_hop          <= hop_q;
			reroute_triggered <= trig;
			window_total      <= sum_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			vld_q     <= '0;
			sum_q     <= '0;
			hop_q     <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < rwrd_pkg::WINDOW_BINS; i++) begin
				bins_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (exec) begin
				if (we) begin
					vld_q[item_s1.slot] <= 1'b1;
				end
				sum_q <= sum_n;
				for (int i = 0; i < rwrd_pkg::WINDOW_BINS; i++) begin
					bins_q[i] <= bins_n[i];
				end
				if (trig) begin
					hop_q <= 1'b1;
				end
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/retransmit_window_reroute_detector.sv
// ----------------------------------------------------------------------------
// retransmit_window_reroute_detector
// Counts first retransmissions per flow in a sliding window of bins and
// latches the backup next hop once the window sum reaches the threshold.
// ----------------------------------------------------------------------------
//   channel  handshake           payload
//   in       in_valid/in_stall   table_index flow_ip retransmit window_tick
//                                flow_timed_out payload_length not_syn
//   out      out_valid/out_stall next_hop reroute_triggered window_total
//   cfg      cfg_valid/cfg_ready cfg_data (reroute_threshold)
//
// The back end takes one packet at a time: it reads the flow table in ST_IDLE
// and updates table, window and result register in ST_EXEC before the next.
// A two-entry queue keeps the input taking packets while the back end works.
// Reset clears the table valid bits at once; no sweep is needed.
// A stalled result holds the back end; the queue then fills and stalls input.
// ----------------------------------------------------------------------------
`default_nettype none

module retransmit_window_reroute_detector (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire  [rwrd_pkg::IDX_W-1:0]  table_index,
	input  wire  [rwrd_pkg::IP_W-1:0]   flow_ip,
	input  wire                         retransmit,
	input  wire                         window_tick,
	input  wire                         flow_timed_out,
	input  wire  [rwrd_pkg::CNT_W-1:0]  payload_length,
	input  wire                         not_syn,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic                        next_hop,
	output logic                        reroute_triggered,
	output logic [rwrd_pkg::CNT_W-1:0]  window_total,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire  [rwrd_pkg::CNT_W-1:0]  cfg_data
);

	rwrd_pkg::qhead_t           head;
	logic                       pop;
	logic [rwrd_pkg::CNT_W-1:0] thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= rwrd_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	rwrd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.table_index    (table_index),
		.flow_ip        (flow_ip),
		.retransmit     (retransmit),
		.window_tick    (window_tick),
		.flow_timed_out (flow_timed_out),
		.payload_length (payload_length),
		.not_syn        (not_syn),
		.head           (head),
		.pop            (pop)
	);

	rwrd_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head              (head),
		.pop               (pop),
		.threshold         (thr_q),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.next_hop          (next_hop),
		.reroute_triggered (reroute_triggered),
		.window_total      (window_total)
	);

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue popped while empty");

	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> head.valid)
		else $error("input stalled with empty queue");

	a_trig_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reroute_triggered |-> window_total >= thr_q)
		else $error("reroute flagged below threshold");

	a_hop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && reroute_triggered) ##1 out_valid[->1]
		|-> next_hop)
		else $error("next hop did not latch after reroute");

endmodule

`default_nettype wire

// File: tb/retransmit_window_reroute_detector_tb.sv
// ----------------------------------------------------------------------------
// retransmit_window_reroute_detector_tb
// Self-checking bench. A scoreboard tracks its own flow table, bin window,
// window sum and hop latch, and predicts one result per packet transaction.
// It runs directed table and window cases, then random traffic over a few
// busy slots with random stalls on both sides at several thresholds, then a
// short burst on one slot with a fresh flow each time.
// ----------------------------------------------------------------------------
module retransmit_window_reroute_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 200;
	localparam int BURST_ITEMS = 40;

	typedef struct packed {
		logic [rwrd_pkg::IDX_W-1:0] index;
		logic [rwrd_pkg::IP_W-1:0]  ip;
		logic                       rtx;
		logic                       tick;
		logic                       evict;
		logic [rwrd_pkg::CNT_W-1:0] plen;
		logic                       nsyn;
	} packet_t;

	typedef struct packed {
		logic                       hop;
		logic                       trig;
		logic [rwrd_pkg::CNT_W-1:0] total;
	} hop_result_t;

	class reroute_scoreboard;
		logic [rwrd_pkg::IP_W-1:0]  flow_ips [rwrd_pkg::TABLE_DEPTH];
		logic                       flow_marks [rwrd_pkg::TABLE_DEPTH];
		logic [rwrd_pkg::CNT_W-1:0] bin_cnt [rwrd_pkg::WINDOW_BINS];
		int unsigned                cur_bin;
		int unsigned                old_bin;
		logic [rwrd_pkg::CNT_W-1:0] win_sum;
		logic                       hop_latched;
		logic [rwrd_pkg::CNT_W-1:0] threshold;
		hop_result_t                pending_results[$];
		int                         errors;

		function new();
			foreach (flow_ips[i]) begin
				flow_ips[i]   = '0;
				flow_marks[i] = 1'b0;
			end
			foreach (bin_cnt[i])
				bin_cnt[i] = '0;
			cur_bin     = rwrd_pkg::WINDOW_BINS - 1;
			old_bin     = 0;
			win_sum     = '0;
			hop_latched = 1'b0;
			threshold   = rwrd_pkg::THR_RESET;
			errors      = 0;
		endfunction

		function void retire_bin();
			win_sum = (win_sum >= bin_cnt[old_bin]) ? win_sum - bin_cnt[old_bin] : '0;
			bin_cnt[old_bin] = '0;
			cur_bin = (cur_bin + 1) % rwrd_pkg::WINDOW_BINS;
			old_bin = (old_bin + 1) % rwrd_pkg::WINDOW_BINS;
		endfunction

		function void mark_first_rtx(int unsigned s);
			flow_marks[s] = 1'b1;
			if (bin_cnt[cur_bin] != rwrd_pkg::CNT_MAX)
				bin_cnt[cur_bin] = bin_cnt[cur_bin] + 1'b1;
			if (win_sum != rwrd_pkg::CNT_MAX)
				win_sum = win_sum + 1'b1;
		endfunction

		function void note_packet(packet_t p);
			hop_result_t r;
			int unsigned s;
			r.hop  = hop_latched;
			r.trig = 1'b0;
			s = int'(p.index);
			if (p.plen != '0 && p.nsyn) begin
				if (p.tick)
					retire_bin();
				if (flow_ips[s] == '0) begin
					flow_ips[s] = p.ip;
					if (p.rtx)
						mark_first_rtx(s);
					else
						flow_marks[s] = 1'b0;
				end else if (flow_ips[s] == p.ip) begin
					if (p.rtx && !flow_marks[s])
						mark_first_rtx(s);
				end else if (p.evict) begin
					flow_ips[s] = p.ip;
					// the evicted flow's mark decides
					if (p.rtx && !flow_marks[s])
						mark_first_rtx(s);
					else
						flow_marks[s] = 1'b0;
				end
				if (win_sum >= threshold) begin
					r.trig      = 1'b1;
					hop_latched = 1'b1;
				end
			end
			r.total = win_sum;
			pending_results.push_back(r);
		endfunction

		function void check_result(logic hop, logic trig,
			logic [rwrd_pkg::CNT_W-1:0] total);
			hop_result_t e;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, actual hop %0d trig %0d total %0d",
					$time, hop, trig, total);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (hop !== e.hop) begin
				$display("%0t: next_hop expected %0d actual %0d", $time, e.hop, hop);
				errors++;
			end
			if (trig !== e.trig) begin
				$display("%0t: reroute_triggered expected %0d actual %0d",
					$time, e.trig, trig);
				errors++;
			end
			if (total !== e.total) begin
				$display("%0t: window_total expected %0d actual %0d", $time, e.total, total);
				errors++;
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic                       clk            = 1'b0;
	logic                       arst_n         = 1'b0;
	logic                       in_valid       = 1'b0;
	logic                       in_stall;
	logic [rwrd_pkg::IDX_W-1:0] table_index    = '0;
	logic [rwrd_pkg::IP_W-1:0]  flow_ip        = '0;
	logic                       retransmit     = 1'b0;
	logic                       window_tick    = 1'b0;
	logic                       flow_timed_out = 1'b0;
	logic [rwrd_pkg::CNT_W-1:0] payload_length = '0;
	logic                       not_syn        = 1'b0;
	logic                       out_valid;
	logic                       out_stall      = 1'b0;
	logic                       next_hop;
	logic                       reroute_triggered;
	logic [rwrd_pkg::CNT_W-1:0] window_total;
	logic                       cfg_valid      = 1'b0;
	logic                       cfg_ready;
	logic [rwrd_pkg::CNT_W-1:0] cfg_data       = '0;

	reroute_scoreboard board;
	int snd_idle_pct  = 26;
	int rcv_idle_pct  = 79;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	retransmit_window_reroute_detector i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.table_index       (table_index),
		.flow_ip           (flow_ip),
		.retransmit        (retransmit),
		.window_tick       (window_tick),
		.flow_timed_out    (flow_timed_out),
		.payload_length    (payload_length),
		.not_syn           (not_syn),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.next_hop          (next_hop),
		.reroute_triggered (reroute_triggered),
		.window_total      (window_total),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side: random stall plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(next_hop, reroute_triggered, window_total);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	function automatic packet_t make_packet(int unsigned index,
		logic [rwrd_pkg::IP_W-1:0] ip, logic rtx, logic tick, logic evict,
		logic [rwrd_pkg::CNT_W-1:0] plen, logic nsyn);
		packet_t p;
		p.index = rwrd_pkg::IDX_W'(index);
		p.ip    = ip;
		p.rtx   = rtx;
		p.tick  = tick;
		p.evict = evict;
		p.plen  = plen;
		p.nsyn  = nsyn;
		return p;
	endfunction

	function automatic packet_t random_packet();
		packet_t p;
		int unsigned pick;
		pick = $urandom_range(99);
		p.index = (pick < 80) ? rwrd_pkg::IDX_W'($urandom_range(0, 7))
			: rwrd_pkg::IDX_W'($urandom_range(0, rwrd_pkg::TABLE_DEPTH - 1));
		pick = $urandom_range(99);
		if (pick < 85)
			p.ip = 32'h0A00_0000 | rwrd_pkg::IP_W'($urandom_range(1, 12));
		else if (pick < 90)
			p.ip = '0;
		else
			p.ip = $urandom;
		p.rtx   = 1'($urandom_range(1));
		p.tick  = ($urandom_range(99) < 15);
		p.evict = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 10)
			p.plen = '0;
		else if (pick < 20)
			p.plen = rwrd_pkg::CNT_W'($urandom_range(0, 65535));
		else
			p.plen = rwrd_pkg::CNT_W'($urandom_range(1, 1500));
		p.nsyn = ($urandom_range(99) < 90);
		return p;
	endfunction

	task automatic send_packet(input packet_t p);
		in_valid       <= 1'b1;
		table_index    <= p.index;
		flow_ip        <= p.ip;
		retransmit     <= p.rtx;
		window_tick    <= p.tick;
		flow_timed_out <= p.evict;
		payload_length <= p.plen;
		not_syn        <= p.nsyn;
		do @(posedge clk); while (in_stall);
		board.note_packet(p);
	endtask

	task automatic sender_gap();
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_threshold(input logic [rwrd_pkg::CNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		board.threshold = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_directed();
		packet_t list[$];
		list.push_back(make_packet(0, 32'h0000_0011, 1'b1, 1'b1, 1'b0, 16'd0, 1'b1));   // ACK only
		list.push_back(make_packet(0, 32'h0000_0011, 1'b1, 1'b1, 1'b0, 16'd1, 1'b0));   // SYN
		list.push_back(make_packet(0, 32'h0000_00A1, 1'b1, 1'b0, 1'b0, 16'd64, 1'b1));  // fill + mark
		list.push_back(make_packet(0, 32'h0000_00A1, 1'b1, 1'b0, 1'b0, 16'd64, 1'b1));  // hit, marked
		list.push_back(make_packet(1, 32'h0000_00B2, 1'b0, 1'b0, 1'b0, 16'd100, 1'b1)); // fill
		list.push_back(make_packet(1, 32'h0000_00B2, 1'b1, 1'b0, 1'b0, 16'd100, 1'b1)); // first rtx
		list.push_back(make_packet(0, 32'h0000_00C3, 1'b1, 1'b0, 1'b0, 16'd10, 1'b1));  // no evict
		list.push_back(make_packet(0, 32'h0000_00C3, 1'b1, 1'b0, 1'b1, 16'd10, 1'b1));  // evict marked
		list.push_back(make_packet(0, 32'h0000_00D4, 1'b1, 1'b0, 1'b1, 16'd10, 1'b1));  // evict
		list.push_back(make_packet(0, 32'h0000_00E5, 1'b0, 1'b0, 1'b1, 16'd10, 1'b1));  // no rtx
		list.push_back(make_packet(2, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 16'd5, 1'b1));   // zero ip
		list.push_back(make_packet(2, 32'h0000_00F6, 1'b1, 1'b0, 1'b0, 16'd5, 1'b1));   // still empty
		list.push_back(make_packet(63, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1));
		for (int i = 0; i < 11; i++)
			list.push_back(make_packet(63, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 16'd1, 1'b1));
		foreach (list[i]) begin
			sender_gap();
			send_packet(list[i]);
		end
	endtask

	task automatic run_random(input int counted_goal, input bit pause_midway);
		packet_t p;
		int counted;
		counted = 0;
		while (counted < counted_goal) begin
			p = random_packet();
			sender_gap();
			send_packet(p);
			if (p.plen != '0 && p.nsyn)
				counted++;
			if (pause_midway && counted == counted_goal / 2)
				drain();
		end
	endtask

	// one slot, fresh ip each time: the mark toggles, one add per two packets
	task automatic one_slot_burst();
		packet_t p;
		p = make_packet(5, '0, 1'b1, 1'b0, 1'b1, 16'd1460, 1'b1);
		for (int k = 0; k < BURST_ITEMS; k++) begin
			p.ip   = 32'h8000_0000 + rwrd_pkg::IP_W'(k);
			p.tick = (k == BURST_ITEMS - 20);
			send_packet(p);
		end
		p = make_packet(5, '0, 1'b0, 1'b1, 1'b0, 16'd1460, 1'b1);
		for (int k = 0; k < 12; k++) begin
			p.ip = 32'h4000_0000 + rwrd_pkg::IP_W'(k);
			send_packet(p);
		end
	endtask

	initial begin
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_threshold(rwrd_pkg::CNT_MAX);
		run_directed();
		drain();
		write_threshold(rwrd_pkg::CNT_W'($urandom_range(6, 14)));
		run_random(210, 1'b0);

		drain();
		snd_idle_pct = 79;
		rcv_idle_pct = 26;
		write_threshold('0);
		run_random(210, 1'b1);

		drain();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		write_threshold(rwrd_pkg::CNT_W'($urandom_range(1, 20)));
		hold_requests++;
		run_random(210, 1'b0);

		drain();
		write_threshold(rwrd_pkg::CNT_MAX);
		one_slot_burst();

		drain();
		repeat (8) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
